/* rtl/markup_text_cleaner_top_defines.svh */
// ----------------------------------------------------------------------------
// Markup text cleaner assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef MARKUP_TEXT_CLEANER_TOP_DEFINES_SVH
`define MARKUP_TEXT_CLEANER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// A condition that holds at every clock edge outside reset.
`define MTC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A trigger that forces a condition at the following clock edge.
`define MTC_ASSERT_NEXT(name, trig, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);
`else
`define MTC_ASSERT(name, prop, msg)
`define MTC_ASSERT_NEXT(name, trig, prop, msg)
`endif

`endif

/* rtl/mtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markup text cleaner package
// Window types, control state, tag patterns and character codes.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int WinDepth = 8;
  localparam int CntW     = 4;

  typedef logic [7:0]                char_t;
  typedef logic [WinDepth-1:0][7:0]  win_t;
  typedef logic [CntW-1:0]           cnt_t;

  typedef struct packed {
    logic [2:0] skip;
    logic       style_on;
    logic       in_list;
    logic       in_tag;
    logic       prev_space;
  } ctl_t;

  typedef struct packed {
    logic  emit;
    char_t ch;
    ctl_t  ctl;
  } res_t;

  localparam char_t CharNl    = 8'h0A;
  localparam char_t CharSpace = 8'h20;
  localparam char_t CharLt    = 8'h3C;
  localparam char_t CharGt    = 8'h3E;
  localparam char_t CharTab   = 8'h09;
  localparam char_t CharCr    = 8'h0D;

  // Element 0 is the first character of each pattern.
  localparam logic [5:0][7:0] PatStyleOpen  = {"e", "l", "y", "t", "s", "<"};
  localparam logic [7:0][7:0] PatStyleClose = {">", "e", "l", "y", "t", "s", "/", "<"};
  localparam logic [2:0][7:0] PatListOpen   = {"l", "o", "<"};
  localparam logic [4:0][7:0] PatListClose  = {">", "l", "o", "/", "<"};

  localparam cnt_t LenStyleOpen  = 4'd6;
  localparam cnt_t LenStyleClose = 4'd8;
  localparam cnt_t LenListOpen   = 4'd3;
  localparam cnt_t LenListClose  = 4'd5;

  localparam logic [2:0] SkipStyleOpen  = 3'd5;
  localparam logic [2:0] SkipStyleClose = 3'd7;
  localparam logic [2:0] SkipListOpen   = 3'd2;
  localparam logic [2:0] SkipListClose  = 3'd4;

  localparam cnt_t CntFull = 4'd8;

endpackage

/* rtl/mtc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markup text cleaner input channel
// Valid/ready channel carrying one text byte and its end-of-text mark.
// ----------------------------------------------------------------------------
interface mtc_in_if;
  logic                valid;
  logic                ready;
  mtc_pkg::char_t      ch;
  logic                end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

/* rtl/mtc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markup text cleaner output channel
// Valid/ready channel carrying one cleaned character and its last mark.
// ----------------------------------------------------------------------------
interface mtc_out_if;
  logic                valid;
  logic                ready;
  mtc_pkg::char_t      out_char;
  logic                out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

/* rtl/mtc_resolve.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markup text cleaner front-byte resolver
// Decides the fate of the window's front byte from the tag patterns ahead of it.
// ----------------------------------------------------------------------------
module mtc_resolve (
  input  mtc_pkg::win_t win,
  input  mtc_pkg::cnt_t count,
  input  mtc_pkg::ctl_t ctl,
  output mtc_pkg::res_t res
);

  logic           m_style_open;
  logic           m_style_close;
  logic           m_list_open;
  logic           m_list_close;
  logic           is_space;
  mtc_pkg::char_t c;

  assign c = win[0];

  assign m_style_open  = (count >= mtc_pkg::LenStyleOpen)
                         && (win[5:0] == mtc_pkg::PatStyleOpen);
  assign m_style_close = (count >= mtc_pkg::LenStyleClose)
                         && (win[7:0] == mtc_pkg::PatStyleClose);
  assign m_list_open   = (count >= mtc_pkg::LenListOpen)
                         && (win[2:0] == mtc_pkg::PatListOpen);
  assign m_list_close  = (count >= mtc_pkg::LenListClose)
                         && (win[4:0] == mtc_pkg::PatListClose);

  assign is_space = (c == mtc_pkg::CharSpace)
                    || ((c >= mtc_pkg::CharTab) && (c <= mtc_pkg::CharCr));

  always_comb begin
    res      = '0;
    res.ctl  = ctl;
    res.ch   = c;
    if (ctl.skip != 3'd0) begin
      res.ctl.skip = ctl.skip - 3'd1;
    end else if (!ctl.style_on && m_style_open) begin
      res.ctl.style_on = 1'b1;
      res.ctl.skip     = mtc_pkg::SkipStyleOpen;
    end else if (ctl.style_on) begin
      if (m_style_close) begin
        res.ctl.style_on = 1'b0;
        res.ctl.skip     = mtc_pkg::SkipStyleClose;
      end
    end else if (!ctl.in_list && m_list_open) begin
      res.ctl.in_list = 1'b1;
      res.ctl.skip    = mtc_pkg::SkipListOpen;
    end else if (ctl.in_list) begin
      if (m_list_close) begin
        res.ctl.in_list = 1'b0;
        res.ctl.skip    = mtc_pkg::SkipListClose;
      end
    end else if (c == mtc_pkg::CharLt) begin
      res.ctl.in_tag = 1'b1;
    end else if (c == mtc_pkg::CharGt) begin
      res.ctl.in_tag = 1'b0;
    end else if (!ctl.in_tag) begin
      if (is_space) begin
        if (!ctl.prev_space) begin
          res.emit           = 1'b1;
          res.ch             = mtc_pkg::CharSpace;
          res.ctl.prev_space = 1'b1;
        end
      end else begin
        res.emit           = 1'b1;
        res.ctl.prev_space = 1'b0;
      end
    end
  end

endmodule

/* rtl/markup_text_cleaner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markup text cleaner
// Strips markup tags, style and ordered-list regions, and folds whitespace.
// ----------------------------------------------------------------------------
// Usage:
//   The text channel takes one byte per word with an end-of-text mark; a zero
//   byte carries no character and gives no result unless it ends a text. The
//   clean channel gives one cleaned character per word, and a closing newline
//   with out_last set after each text.
//   A byte is held in an eight-entry lookahead window and is resolved when
//   the window fills, so output trails input by seven characters. A result
//   appears in the cycle after the word that resolves it. Streaming words are
//   taken at one per cycle while the output buffer has a free slot.
//   The end-of-text word starts a drain that resolves one held byte per cycle
//   while the output buffer has room and then sends the newline; no text
//   word is taken during the drain.
//   A two-word output buffer lets a new text word be taken while one result
//   waits; when the receiver stalls with both slots full, ready drops.
//   Reset clears the window count, region flags and the output buffer.
// ----------------------------------------------------------------------------
`include "markup_text_cleaner_top_defines.svh"

module markup_text_cleaner_top (
  input  logic            clk,
  input  logic            rst,
  mtc_in_if.sink          text,
  mtc_out_if.source       clean
);

  typedef enum logic {
    ST_STREAM,
    ST_DRAIN
  } mode_t;

  mode_t               mode;
  mode_t               mode_next;
  mtc_pkg::win_t       win;
  mtc_pkg::win_t       win_next;
  mtc_pkg::cnt_t       pcount;
  mtc_pkg::cnt_t       pcount_next;
  mtc_pkg::ctl_t       ctl;
  mtc_pkg::ctl_t       ctl_next;

  mtc_pkg::char_t      fq_char [2];
  logic                fq_last [2];
  logic                rd_ptr;
  logic                wr_ptr;
  logic [1:0]          fcount;

  logic                space;
  logic                acc;
  logic                pop;
  logic                ch_nz;
  mtc_pkg::win_t       win_ins;
  mtc_pkg::cnt_t       pcount_ins;
  mtc_pkg::win_t       rwin;
  mtc_pkg::cnt_t       rcount;
  mtc_pkg::win_t       rwin_shift;
  mtc_pkg::res_t       res;
  logic                do_res;
  logic                push;
  mtc_pkg::char_t      push_char;
  logic                push_last;

  assign space       = (fcount != 2'd2);
  assign text.ready  = (mode == ST_STREAM) && space;
  assign acc         = text.valid && text.ready;
  assign pop         = clean.valid && clean.ready;
  assign ch_nz       = (text.ch != 8'h00);

  assign clean.valid    = (fcount != 2'd0);
  assign clean.out_char = fq_char[rd_ptr];
  assign clean.out_last = fq_last[rd_ptr];

  always_comb begin
    for (int i = 0; i < mtc_pkg::WinDepth; i++) begin
      win_ins[i] = (ch_nz && (pcount[2:0] == 3'(i))) ? text.ch : win[i];
    end
  end

  assign pcount_ins = pcount + {3'b000, ch_nz};
  assign rwin       = (mode == ST_DRAIN) ? win : win_ins;
  assign rcount     = (mode == ST_DRAIN) ? pcount : pcount_ins;

  always_comb begin
    for (int i = 0; i < mtc_pkg::WinDepth - 1; i++) begin
      rwin_shift[i] = rwin[i+1];
    end
    rwin_shift[mtc_pkg::WinDepth-1] = rwin[mtc_pkg::WinDepth-1];
  end

  mtc_resolve u_resolve (
    .win   (rwin),
    .count (rcount),
    .ctl   (ctl),
    .res   (res)
  );

  always_comb begin
    mode_next   = mode;
    win_next    = win;
    pcount_next = pcount;
    ctl_next    = ctl;
    do_res      = 1'b0;
    push        = 1'b0;
    push_char   = res.ch;
    push_last   = 1'b0;
    case (mode)
      ST_STREAM: begin
        if (acc) begin
          do_res = !text.end_of_text && (pcount_ins == mtc_pkg::CntFull);
          if (do_res) begin
            win_next    = rwin_shift;
            pcount_next = pcount_ins - 4'd1;
            ctl_next    = res.ctl;
            push        = res.emit;
          end else begin
            win_next    = win_ins;
            pcount_next = pcount_ins;
          end
          if (text.end_of_text) begin
            mode_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (space) begin
          if (pcount != 4'd0) begin
            do_res      = 1'b1;
            win_next    = rwin_shift;
            pcount_next = pcount - 4'd1;
            ctl_next    = res.ctl;
            push        = res.emit;
          end else begin
            push        = 1'b1;
            push_char   = mtc_pkg::CharNl;
            push_last   = 1'b1;
            pcount_next = '0;
            ctl_next    = '0;
            mode_next   = ST_STREAM;
          end
        end
      end
      default: begin
        mode_next = ST_STREAM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    win <= win_next;
    if (push) begin
      fq_char[wr_ptr] <= push_char;
      fq_last[wr_ptr] <= push_last;
    end
    if (rst) begin
      mode   <= ST_STREAM;
      pcount <= '0;
      ctl    <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fcount <= 2'd0;
    end else begin
      mode   <= mode_next;
      pcount <= pcount_next;
      ctl    <= ctl_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fcount <= fcount + {1'b0, push} - {1'b0, pop};
    end
  end

  `MTC_ASSERT(a_fifo_bound, fcount != 2'd3, "output buffer overflow")
  `MTC_ASSERT(a_stream_room, (mode != ST_STREAM) || (pcount <= 4'd7), "window full while streaming")
  `MTC_ASSERT(a_last_is_newline, !(clean.valid && clean.out_last) || (clean.out_char == mtc_pkg::CharNl), "last word is not a newline")
  `MTC_ASSERT_NEXT(a_newline_resets, push && push_last, (pcount == 4'd0) && (mode == ST_STREAM) && (ctl == '0), "state not cleared after newline")

endmodule
